// ===== rtl/multi_key_debounce_scanner_unit_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef MULTI_KEY_DEBOUNCE_SCANNER_UNIT_DEFINES_SVH
`define MULTI_KEY_DEBOUNCE_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MKDS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MKDS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/mkds_pkg.sv =====
package mkds_pkg;

  // Key count the item fields can carry.
  localparam int FIELD_KEYS = 8;
  localparam int CNT_W      = 8;
  localparam int IDX_W      = 3;
  localparam int STATES_W   = 2 * FIELD_KEYS;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;

  // Register map
  localparam logic [1:0] ADDR_DEBOUNCE = 2'd0;

  // Transaction kinds on the input side
  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESS   = 2'd1,
    ST_HOLD    = 2'd2,
    ST_RELEASE = 2'd3
  } key_state_t;

  // Per-step control shared by all key lanes
  typedef struct packed {
    logic             step;
    logic             scan;
    logic [CNT_W-1:0] thr;
  } lane_ctl_t;

endpackage

// ===== rtl/mkds_key_lane.sv =====
module mkds_key_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  mkds_pkg::lane_ctl_t   ctl,
  input  logic                  down,
  input  logic                  take_hit,
  output mkds_pkg::key_state_t  state,
  output mkds_pkg::key_state_t  state_next
);

  logic [mkds_pkg::CNT_W-1:0] count;
  logic [mkds_pkg::CNT_W-1:0] count_next;
  logic [mkds_pkg::CNT_W-1:0] count_inc;

  assign count_inc = count + mkds_pkg::CNT_W'(1);

  always_comb begin
    state_next = state;
    count_next = count;
    if (ctl.step) begin
      if (ctl.scan) begin
        if (down) begin
          if (count < ctl.thr) begin
            count_next = count_inc;
            if (count_inc == ctl.thr) begin
              state_next = mkds_pkg::ST_PRESS;
            end
          end else begin
            state_next = mkds_pkg::ST_HOLD;
          end
        end else begin
          state_next = (count >= ctl.thr) ? mkds_pkg::ST_RELEASE : mkds_pkg::ST_IDLE;
          count_next = '0;
        end
      end else if (take_hit) begin
        state_next = mkds_pkg::ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mkds_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

// ===== rtl/mkds_take_pick.sv =====
module mkds_take_pick #(
  parameter int LANES = 8
) (
  input  logic [LANES-1:0]           press,
  output logic [LANES-1:0]           hit,
  output logic                       found,
  output logic [mkds_pkg::IDX_W-1:0] index
);

  // Isolate the lowest set bit.
  assign hit   = press & (~press + LANES'(1));
  assign found = |press;

  always_comb begin
    index = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (press[i]) begin
        index = mkds_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/multi_key_debounce_scanner_unit.sv =====
// Debounce scanner for up to eight active-low keys. Each input transaction is
// either a scan tick (tuser = 0, tdata carries the pin levels) or a take
// (tuser = 1), which moves the lowest-numbered key in press to hold. Every
// transaction returns one result with all key statuses, the queried status,
// a press summary and the take outcome. One transaction is accepted per clock
// while the result stream is not stalled; a result passes through the input
// register, then one update of the per-key status and counter registers into
// the result register. The user must write the debounce threshold over APB at
// address 0 only while the block is idle; the block does not enforce this.
module multi_key_debounce_scanner_unit #(
  parameter int KEYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // raw_levels[7:0], query_index[10:8], zero
  input  logic        s_axis_tuser,  // mode
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // key_states[15:0], queried_state[17:16], any_fresh_press[18],
  // trigger_valid[19], trigger_index[22:20], zero
  output logic [23:0] m_axis_tdata
);

  localparam int LANES = (KEYS < mkds_pkg::FIELD_KEYS) ? KEYS : mkds_pkg::FIELD_KEYS;

  // Configuration
  logic [mkds_pkg::CNT_W-1:0] debounce_ticks;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == mkds_pkg::ADDR_DEBOUNCE);
  assign prdata    = (paddr == mkds_pkg::ADDR_DEBOUNCE) ? 32'(debounce_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= mkds_pkg::DEBOUNCE_RESET;
    end else if (cfg_write) begin
      debounce_ticks <= pwdata[mkds_pkg::CNT_W-1:0];
    end
  end

  // Input register
  logic                              in_valid;
  logic                              in_mode;
  logic [mkds_pkg::FIELD_KEYS-1:0]   in_levels;
  logic [mkds_pkg::IDX_W-1:0]        in_query;
  logic                              out_valid;
  logic                              advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode   <= s_axis_tuser;
      in_levels <= s_axis_tdata[7:0];
      in_query  <= s_axis_tdata[10:8];
    end
  end

  // Key lanes
  mkds_pkg::lane_ctl_t        ctl;
  mkds_pkg::key_state_t       state      [LANES];
  mkds_pkg::key_state_t       state_next [LANES];
  logic [LANES-1:0]           press;
  logic [LANES-1:0]           press_next;
  logic [LANES-1:0]           hit;
  logic                       found;
  logic [mkds_pkg::IDX_W-1:0] pick_index;

  assign ctl.step = advance;
  assign ctl.scan = (in_mode == mkds_pkg::MODE_SCAN);
  assign ctl.thr  = debounce_ticks;

  mkds_take_pick #(.LANES(LANES)) u_pick (
    .press (press),
    .hit   (hit),
    .found (found),
    .index (pick_index)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mkds_key_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .down       (!in_levels[g]),
      .take_hit   (hit[g]),
      .state      (state[g]),
      .state_next (state_next[g])
    );
    assign press[g]      = (state[g] == mkds_pkg::ST_PRESS);
    assign press_next[g] = (state_next[g] == mkds_pkg::ST_PRESS);
  end

  // Result assembly; absent keys read as idle
  logic [mkds_pkg::STATES_W-1:0] states_packed;
  logic [1:0]                    queried;
  logic                          take_ok;

  always_comb begin
    states_packed = '0;
    for (int i = 0; i < LANES; i++) begin
      states_packed[2*i +: 2] = state_next[i];
    end
  end

  assign queried = states_packed[{in_query, 1'b0} +: 2];
  assign take_ok = (in_mode == mkds_pkg::MODE_TAKE) && found;

  // Result register
  logic [mkds_pkg::STATES_W-1:0] out_states;
  logic [1:0]                    out_queried;
  logic                          out_any;
  logic                          out_trig;
  logic [mkds_pkg::IDX_W-1:0]    out_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_states  <= states_packed;
      out_queried <= queried;
      out_any     <= |press_next;
      out_trig    <= take_ok;
      out_index   <= take_ok ? pick_index : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_index, out_trig, out_any, out_queried, out_states};

endmodule

// ===== rtl/mkds_checker.sv =====
`include "multi_key_debounce_scanner_unit_defines.svh"

module mkds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic [15:0] states;
  logic [1:0]  taken_state;
  logic        press_seen;

  assign states      = m_axis_tdata[15:0];
  assign taken_state = 2'(states >> {m_axis_tdata[22:20], 1'b0});

  always_comb begin
    press_seen = 1'b0;
    for (int i = 0; i < mkds_pkg::FIELD_KEYS; i++) begin
      if (states[2*i +: 2] == mkds_pkg::ST_PRESS) begin
        press_seen = 1'b1;
      end
    end
  end

  // A consumed key must show as hold in the same result.
  `MKDS_ASSERT_NOW(a_taken_is_hold, m_axis_tvalid && m_axis_tdata[19], taken_state == mkds_pkg::ST_HOLD, "taken key not in hold")

  `MKDS_ASSERT_NOW(a_index_zero, m_axis_tvalid && !m_axis_tdata[19], m_axis_tdata[22:20] == 3'd0, "trigger index set without trigger")

  `MKDS_ASSERT_NOW(a_any_matches, m_axis_tvalid, m_axis_tdata[18] == press_seen, "press summary disagrees with key statuses")

  `MKDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind multi_key_debounce_scanner_unit mkds_checker u_mkds_checker (.*);
